### hdl/tls_pkg.sv
// Shared types, constants and helpers for the traffic light sequencer.
// Used by every module in this folder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tls_pkg;

  // Default counter width and the fixed width of each configuration register.
  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CFG_WIDTH       = 16;
  localparam int NUM_REGS        = 8;
  localparam int CFG_IDX_WIDTH   = 3;
  localparam int PHASE_WIDTH     = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GREEN_TIME        = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GREEN_BLINK_TIME  = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_YELLOW_TIME       = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RED_TIME          = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RED_YELLOW_TIME   = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BLINK_INTERVAL    = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_YELLOW_BLINK_TIME = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE_TIME     = 3'd7;

  // Reset values of the configuration registers, in milliseconds.
  localparam logic [CFG_WIDTH-1:0] RST_GREEN_TIME        = 16'd5000;
  localparam logic [CFG_WIDTH-1:0] RST_GREEN_BLINK_TIME  = 16'd3000;
  localparam logic [CFG_WIDTH-1:0] RST_YELLOW_TIME       = 16'd2000;
  localparam logic [CFG_WIDTH-1:0] RST_RED_TIME          = 16'd5000;
  localparam logic [CFG_WIDTH-1:0] RST_RED_YELLOW_TIME   = 16'd2000;
  localparam logic [CFG_WIDTH-1:0] RST_BLINK_INTERVAL    = 16'd500;
  localparam logic [CFG_WIDTH-1:0] RST_YELLOW_BLINK_TIME = 16'd4000;
  localparam logic [CFG_WIDTH-1:0] RST_DEBOUNCE_TIME     = 16'd50;

  // Phase codes as they appear on the result word.
  localparam logic [PHASE_WIDTH-1:0] CODE_GREEN        = 3'd0;
  localparam logic [PHASE_WIDTH-1:0] CODE_GREEN_BLINK  = 3'd1;
  localparam logic [PHASE_WIDTH-1:0] CODE_YELLOW       = 3'd2;
  localparam logic [PHASE_WIDTH-1:0] CODE_RED          = 3'd3;
  localparam logic [PHASE_WIDTH-1:0] CODE_RED_YELLOW   = 3'd4;
  localparam logic [PHASE_WIDTH-1:0] CODE_YELLOW_BLINK = 3'd5;

  // Lamp sequencer state, one-hot.
  typedef enum logic [5:0] {
    PH_GREEN        = 6'b000001,
    PH_GREEN_BLINK  = 6'b000010,
    PH_YELLOW       = 6'b000100,
    PH_RED          = 6'b001000,
    PH_RED_YELLOW   = 6'b010000,
    PH_YELLOW_BLINK = 6'b100000
  } phase_t;

  // Configuration register bank as seen by the step logic.
  typedef struct packed {
    logic [CFG_WIDTH-1:0] green_time;
    logic [CFG_WIDTH-1:0] green_blink_time;
    logic [CFG_WIDTH-1:0] yellow_time;
    logic [CFG_WIDTH-1:0] red_time;
    logic [CFG_WIDTH-1:0] red_yellow_time;
    logic [CFG_WIDTH-1:0] blink_interval;
    logic [CFG_WIDTH-1:0] yellow_blink_time;
    logic [CFG_WIDTH-1:0] debounce_time;
  } cfg_t;

  // Phase and blink levels, everything of the state but the counters.
  typedef struct packed {
    phase_t phase;
    logic   green_lvl;
    logic   yellow_lvl;
  } seq_state_t;

  // One result word.
  typedef struct packed {
    logic                   red_on;
    logic                   yellow_on;
    logic                   green_on;
    logic [PHASE_WIDTH-1:0] phase;
  } lamp_word_t;

endpackage

`default_nettype wire

### hdl/tls_cfg_regs.sv
// Configuration register bank of the traffic light sequencer.
// Depends on tls_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module tls_cfg_regs
  import tls_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [CFG_IDX_WIDTH-1:0] wr_index,
  input  wire logic [CFG_WIDTH-1:0]     wr_data,
  output cfg_t                          cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index of a write.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_GREEN_TIME:        cfg_nxt.green_time        = wr_data;
        REG_GREEN_BLINK_TIME:  cfg_nxt.green_blink_time  = wr_data;
        REG_YELLOW_TIME:       cfg_nxt.yellow_time       = wr_data;
        REG_RED_TIME:          cfg_nxt.red_time          = wr_data;
        REG_RED_YELLOW_TIME:   cfg_nxt.red_yellow_time   = wr_data;
        REG_BLINK_INTERVAL:    cfg_nxt.blink_interval    = wr_data;
        REG_YELLOW_BLINK_TIME: cfg_nxt.yellow_blink_time = wr_data;
        REG_DEBOUNCE_TIME:     cfg_nxt.debounce_time     = wr_data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  // Registers come out of reset with the default timing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.green_time        <= RST_GREEN_TIME;
      cfg_r.green_blink_time  <= RST_GREEN_BLINK_TIME;
      cfg_r.yellow_time       <= RST_YELLOW_TIME;
      cfg_r.red_time          <= RST_RED_TIME;
      cfg_r.red_yellow_time   <= RST_RED_YELLOW_TIME;
      cfg_r.blink_interval    <= RST_BLINK_INTERVAL;
      cfg_r.yellow_blink_time <= RST_YELLOW_BLINK_TIME;
      cfg_r.debounce_time     <= RST_DEBOUNCE_TIME;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### hdl/tls_step.sv
// Next-state and lamp logic for one millisecond tick of the sequencer.
// Depends on tls_pkg for phase_t, cfg_t, seq_state_t and lamp_word_t.
`timescale 1ns / 1ps
`default_nettype none

module tls_step
  import tls_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic [TIMER_WIDTH-1:0] phase_elapsed,
  input  wire logic [TIMER_WIDTH-1:0] blink_elapsed,
  input  wire logic [TIMER_WIDTH-1:0] since_press,
  input  wire seq_state_t             seq,
  input  wire cfg_t                   cfg,
  input  wire logic                   button_press,
  output logic [TIMER_WIDTH-1:0]      phase_elapsed_nxt,
  output logic [TIMER_WIDTH-1:0]      blink_elapsed_nxt,
  output logic [TIMER_WIDTH-1:0]      since_press_nxt,
  output seq_state_t                  seq_nxt,
  output lamp_word_t                  word
);

  // Compare width covers both the counters and the 16-bit register values.
  localparam int CW = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

  logic [TIMER_WIDTH-1:0] pe;
  logic [TIMER_WIDTH-1:0] be;
  logic [TIMER_WIDTH-1:0] sp;
  logic [TIMER_WIDTH-1:0] pe_p;
  logic [TIMER_WIDTH-1:0] be_p;
  logic                   press_ok;
  logic                   phase_done;
  logic                   blink_due;
  logic                   restart_phase;
  logic                   restart_blink;
  logic [CFG_WIDTH-1:0]   phase_len;
  seq_state_t             s;

  // Saturating increments of the three counters.
  always_comb begin
    pe = (phase_elapsed == '1) ? phase_elapsed : phase_elapsed + TIMER_WIDTH'(1);
    be = (blink_elapsed == '1) ? blink_elapsed : blink_elapsed + TIMER_WIDTH'(1);
    sp = (since_press == '1) ? since_press : since_press + TIMER_WIDTH'(1);
  end

  assign press_ok = button_press && (CW'(sp) >= CW'(cfg.debounce_time));

  // Debounced press forces yellow blinking unless it is already running.
  always_comb begin
    s               = seq;
    pe_p            = pe;
    be_p            = be;
    since_press_nxt = sp;
    if (press_ok) begin
      since_press_nxt = '0;
      if (seq.phase != PH_YELLOW_BLINK) begin
        s.phase      = PH_YELLOW_BLINK;
        s.yellow_lvl = 1'b1;
        pe_p         = '0;
        be_p         = '0;
      end
    end
  end

  // Length of the phase that is running after the press has been judged.
  always_comb begin
    unique case (s.phase)
      PH_GREEN_BLINK:  phase_len = cfg.green_blink_time;
      PH_YELLOW:       phase_len = cfg.yellow_time;
      PH_RED:          phase_len = cfg.red_time;
      PH_RED_YELLOW:   phase_len = cfg.red_yellow_time;
      PH_YELLOW_BLINK: phase_len = cfg.yellow_blink_time;
      default:         phase_len = cfg.green_time;
    endcase
  end

  assign phase_done = CW'(pe_p) >= CW'(phase_len);
  assign blink_due  = CW'(be_p) >= CW'(cfg.blink_interval);

  // Phase timeout, and the blink toggle in a blinking phase that stays.
  always_comb begin
    seq_nxt = s;
    unique case (s.phase)
      PH_GREEN_BLINK: begin
        if (phase_done) begin
          seq_nxt.phase = PH_YELLOW;
        end else if (blink_due) begin
          seq_nxt.green_lvl = !s.green_lvl;
        end
      end
      PH_YELLOW: begin
        if (phase_done) begin
          seq_nxt.phase = PH_RED;
        end
      end
      PH_RED: begin
        if (phase_done) begin
          seq_nxt.phase = PH_RED_YELLOW;
        end
      end
      PH_RED_YELLOW: begin
        if (phase_done) begin
          seq_nxt.phase = PH_GREEN;
        end
      end
      PH_YELLOW_BLINK: begin
        if (phase_done) begin
          seq_nxt.phase = PH_GREEN;
        end else if (blink_due) begin
          seq_nxt.yellow_lvl = !s.yellow_lvl;
        end
      end
      default: begin
        seq_nxt.phase = PH_GREEN;
        if (phase_done) begin
          seq_nxt.phase     = PH_GREEN_BLINK;
          seq_nxt.green_lvl = 1'b1;
        end
      end
    endcase
  end

  // Counter restarts that go with a timeout or a blink toggle.
  // The press-forced restart is already folded into the values above.
  assign restart_phase = phase_done;
  assign restart_blink = blink_due &&
                         ((s.phase == PH_GREEN_BLINK) || (s.phase == PH_YELLOW_BLINK));

  always_comb begin
    phase_elapsed_nxt = pe_p;
    blink_elapsed_nxt = be_p;
    if (restart_phase) begin
      phase_elapsed_nxt = '0;
      // Entering the green blinking phase also restarts the blink counter.
      if ((s.phase == PH_GREEN) || (s.phase != PH_GREEN_BLINK && s.phase != PH_YELLOW &&
          s.phase != PH_RED && s.phase != PH_RED_YELLOW && s.phase != PH_YELLOW_BLINK)) begin
        blink_elapsed_nxt = '0;
      end
    end else if (restart_blink) begin
      blink_elapsed_nxt = '0;
    end
  end

  // Lamp drive and phase code for the new state.
  always_comb begin
    word = '0;
    unique case (seq_nxt.phase)
      PH_GREEN_BLINK: begin
        word.green_on = seq_nxt.green_lvl;
        word.phase    = CODE_GREEN_BLINK;
      end
      PH_YELLOW: begin
        word.yellow_on = 1'b1;
        word.phase     = CODE_YELLOW;
      end
      PH_RED: begin
        word.red_on = 1'b1;
        word.phase  = CODE_RED;
      end
      PH_RED_YELLOW: begin
        word.red_on    = 1'b1;
        word.yellow_on = 1'b1;
        word.phase     = CODE_RED_YELLOW;
      end
      PH_YELLOW_BLINK: begin
        word.yellow_on = seq_nxt.yellow_lvl;
        word.phase     = CODE_YELLOW_BLINK;
      end
      default: begin
        word.green_on = 1'b1;
        word.phase    = CODE_GREEN;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/traffic_light_sequencer_core.sv
// Top level of the traffic light sequencer: input stage, state registers, result register.
// Depends on tls_pkg, tls_cfg_regs and tls_step.
//
//   channel  direction  handshake           word
//   in_      input      in_valid/in_stall   button_press
//   out_     output     out_valid/out_stall red_on, yellow_on, green_on, phase
//   cfg_     input      cfg_valid/cfg_ready index (3 bits), data (16 bits)
//
// Each word goes input register -> step logic -> result register, and out_valid rises
// once the word is in the result register. One tick and one new word are taken every
// cycle while in_stall is low; the phase and counter register loop sets that rate.
// rst_n is synchronous: it empties both stages and loads the default timing.
// A held out_stall stalls the input once both the input and result registers hold a word.
// cfg_ready is always high; a write takes effect at the next edge.
`timescale 1ns / 1ps
`default_nettype none

module traffic_light_sequencer_core
  import tls_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_button_press,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_red_on,
  output logic                          out_yellow_on,
  output logic                          out_green_on,
  output logic [PHASE_WIDTH-1:0]        out_phase,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]     cfg_data
);

  cfg_t                   cfg;
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic                   s1_press_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  lamp_word_t             out_word_r;
  lamp_word_t             word;
  logic                   advance;
  logic                   in_fire;
  seq_state_t             seq_r;
  seq_state_t             seq_nxt;
  logic [TIMER_WIDTH-1:0] phase_elapsed_r;
  logic [TIMER_WIDTH-1:0] phase_elapsed_nxt;
  logic [TIMER_WIDTH-1:0] blink_elapsed_r;
  logic [TIMER_WIDTH-1:0] blink_elapsed_nxt;
  logic [TIMER_WIDTH-1:0] since_press_r;
  logic [TIMER_WIDTH-1:0] since_press_nxt;

  assign cfg_ready = 1'b1;

  tls_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The input stage moves on whenever the result register is free or being emptied.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  tls_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .phase_elapsed     (phase_elapsed_r),
    .blink_elapsed     (blink_elapsed_r),
    .since_press       (since_press_r),
    .seq               (seq_r),
    .cfg               (cfg),
    .button_press      (s1_press_r),
    .phase_elapsed_nxt (phase_elapsed_nxt),
    .blink_elapsed_nxt (blink_elapsed_nxt),
    .since_press_nxt   (since_press_nxt),
    .seq_nxt           (seq_nxt),
    .word              (word)
  );

  // Handshake state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequencer state advances once per tick that leaves the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r.phase      <= PH_GREEN;
      seq_r.green_lvl  <= 1'b1;
      seq_r.yellow_lvl <= 1'b0;
      phase_elapsed_r  <= '0;
      blink_elapsed_r  <= '0;
      since_press_r    <= '0;
    end else if (advance) begin
      seq_r           <= seq_nxt;
      phase_elapsed_r <= phase_elapsed_nxt;
      blink_elapsed_r <= blink_elapsed_nxt;
      since_press_r   <= since_press_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_press_r <= in_button_press;
    end
    if (advance) begin
      out_word_r <= word;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_on    = out_word_r.red_on;
  assign out_yellow_on = out_word_r.yellow_on;
  assign out_green_on  = out_word_r.green_on;
  assign out_phase     = out_word_r.phase;

endmodule

`default_nettype wire

### hdl/tls_checker.sv
// Port-level checks for the traffic light sequencer, bound to its top level.
// Depends on tls_pkg for the phase codes and on traffic_light_sequencer_core.
`timescale 1ns / 1ps
`default_nettype none

module tls_checker
  import tls_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic                   out_red_on,
  input wire logic                   out_yellow_on,
  input wire logic                   out_green_on,
  input wire logic [PHASE_WIDTH-1:0] out_phase
);

  // A reset cycle leaves no result word behind.
  a_reset_empties : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present right after reset");

  // A stalled result word holds until it is taken.
  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_phase) &&
      $stable(out_red_on) && $stable(out_yellow_on) && $stable(out_green_on))
    else $error("stalled result word changed");

  // Only the six defined phase codes are delivered.
  a_phase_code : assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> out_phase <= CODE_YELLOW_BLINK)
    else $error("undefined phase code delivered");

  // Red lights only in the red phases, green only in the green phases.
  a_red_green : assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_red_on == (out_phase == CODE_RED || out_phase == CODE_RED_YELLOW)) &&
      (!out_green_on || out_phase == CODE_GREEN || out_phase == CODE_GREEN_BLINK) &&
      (out_green_on || out_phase != CODE_GREEN))
    else $error("lamp drive disagrees with phase");

  // Yellow is steady in the yellow phases and dark in the green and red phases.
  a_yellow : assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_phase == CODE_YELLOW || out_phase == CODE_RED_YELLOW ||
      out_phase == CODE_GREEN || out_phase == CODE_GREEN_BLINK || out_phase == CODE_RED)
      |-> out_yellow_on == (out_phase == CODE_YELLOW || out_phase == CODE_RED_YELLOW))
    else $error("yellow lamp disagrees with phase");

endmodule

bind traffic_light_sequencer_core tls_checker u_tls_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_red_on    (out_red_on),
  .out_yellow_on (out_yellow_on),
  .out_green_on  (out_green_on),
  .out_phase     (out_phase)
);

`default_nettype wire
